/* hw/rtl/touch_gesture_to_mouse_assert.svh */
// Assertion macros for the gesture-to-mouse block.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef TOUCH_GESTURE_TO_MOUSE_ASSERT_SVH
`define TOUCH_GESTURE_TO_MOUSE_ASSERT_SVH

// Same-cycle implication, off during reset.
`define TGM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define TGM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/tgm_pkg.sv */
// Shared types and constants of the gesture-to-mouse block.
// No dependencies; used by touch_gesture_to_mouse.
package tgm_pkg;

    localparam int SAMPLE_DEPTH_DEF = 32;
    localparam int FRAC_BITS_DEF    = 12;

    // request codes
    localparam logic [1:0] REQ_DOWN = 2'd0;
    localparam logic [1:0] REQ_MOVE = 2'd1;
    localparam logic [1:0] REQ_UP   = 2'd2;
    localparam logic [1:0] REQ_TICK = 2'd3;

    // action codes
    localparam logic [2:0] ACT_LCLICK   = 3'd0;
    localparam logic [2:0] ACT_RCLICK   = 3'd1;
    localparam logic [2:0] ACT_LPRESS   = 3'd2;
    localparam logic [2:0] ACT_MOVE     = 3'd3;
    localparam logic [2:0] ACT_LRELEASE = 3'd4;
    localparam logic [2:0] ACT_WHEEL    = 3'd5;
    localparam logic [2:0] ACT_PARK     = 3'd6;

    // configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INERTIA_PERIOD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INERTIA_DECAY  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_INERTIA_START  = 3'd7;

    // register reset values
    localparam logic [7:0]  RST_MOVE_THRESHOLD = 8'd12;
    localparam logic [15:0] RST_LONG_PRESS     = 16'd500;
    localparam logic [3:0]  RST_WHEEL_GAIN     = 4'd3;
    localparam logic [14:0] RST_WHEEL_LIMIT    = 15'd360;
    localparam logic [9:0]  RST_WINDOW         = 10'd100;
    localparam logic [7:0]  RST_INERTIA_PERIOD = 8'd12;
    localparam logic [15:0] RST_INERTIA_DECAY  = 16'd58982;
    localparam logic [20:0] RST_INERTIA_START  = 21'd4915;

    localparam logic [15:0] START_SCALE = 16'd62259;   // 0.95 in Q0.16
    localparam logic [15:0] WHEEL_MULT  = 16'd80;
    localparam logic [19:0] TIME_MAX    = 20'hFFFFF;
    localparam logic signed [16:0] SMALL_DY = 17'sd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [15:0]        pointer_id;
        logic               is_touch;
        logic               target_active;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
    } t_in_word;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] wheel_delta;
        logic               last;
    } t_out_word;

endpackage

/* hw/rtl/tgm_div.sv */
// Restoring serial divider, one quotient bit per cycle.
// Standalone; instantiated by touch_gesture_to_mouse.
module tgm_div #(
    parameter int NUM_W = 35,
    parameter int DEN_W = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;

    logic [DEN_W:0]   n_rem_sh;
    logic             n_bit;
    logic [DEN_W:0]   n_rem;

    always_comb begin
        n_rem_sh = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
        n_bit    = (n_rem_sh >= {1'b0, r_den});
        n_rem    = n_bit ? (n_rem_sh - {1'b0, r_den}) : n_rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[NUM_W-2:0], n_bit};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

/* hw/rtl/touch_gesture_to_mouse.sv */
// Gesture engine: touch down/move/up and 1 ms ticks in, mouse actions out.
// One word at a time; o_in_stall stays high from accept until all results have left.
// Handling time depends on the request: a move may drop samples that fell out of the window, a tick
// may run an inertia step, and a scroll release walks every stored sample, then runs a serial divide of
// 18+log2(SAMPLE_DEPTH)+FRAC_BITS quotient bits (35 at defaults). The divider and sample walk set the longest.
// Synchronous active-low reset clears control state; the sample store is not cleared.
module touch_gesture_to_mouse #(
    parameter int SAMPLE_DEPTH = tgm_pkg::SAMPLE_DEPTH_DEF,
    parameter int FRAC_BITS    = tgm_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  tgm_pkg::t_in_word                  i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output tgm_pkg::t_out_word                 o_out_word,
    input  logic                               i_cfg_we,
    input  logic [tgm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tgm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

`include "touch_gesture_to_mouse_assert.svh"

    localparam int PW     = $clog2(SAMPLE_DEPTH);
    localparam int CW     = $clog2(SAMPLE_DEPTH + 1);
    localparam int SW     = CW + 1;
    localparam int SUM_W  = 18 + PW;
    localparam int NUM_W  = SUM_W + FRAC_BITS;
    localparam int VM_W   = 9 + FRAC_BITS;
    localparam int MA_W   = 10 + FRAC_BITS;
    localparam int PROD_W = MA_W + 16;
    localparam logic [VM_W-1:0] VEL_CAP  = VM_W'(360 * (2 ** FRAC_BITS));
    localparam logic [MA_W-1:0] Q_CLAMP  = MA_W'(720 * (2 ** FRAC_BITS));
    localparam logic [VM_W-1:0] STOP_MIN = VM_W'(((2 ** FRAC_BITS) + 99) / 100);

    typedef enum logic [1:0] {M_IDLE, M_PEND, M_SCROLL, M_DRAG} t_mode;

    typedef enum logic [4:0] {
        S_IDLE, S_EXEC, S_WMUL, S_WEMIT, S_REC, S_WRD, S_WCHK, S_VRD, S_VACC,
        S_DSTART, S_DWAIT, S_SMUL, S_SSET, S_DMUL, S_DSET, S_HMUL, S_HEMIT, S_SEND
    } t_state;

    function automatic logic [16:0] abs17(input logic signed [16:0] v);
        return v[16] ? 17'(-v) : 17'(v);
    endfunction

    function automatic logic [SUM_W-1:0] abs_sum(input logic signed [SUM_W-1:0] v);
        return v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
    endfunction

    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(off);
        if (s >= SW'(SAMPLE_DEPTH)) s = s - SW'(SAMPLE_DEPTH);
        return PW'(s);
    endfunction

    // configuration
    logic [7:0]  r_cfg_thr;
    logic [15:0] r_cfg_long;
    logic [3:0]  r_cfg_gain;
    logic [14:0] r_cfg_limit;
    logic [9:0]  r_cfg_window;
    logic [7:0]  r_cfg_period;
    logic [15:0] r_cfg_decay;
    logic [20:0] r_cfg_start_min;

    // gesture state
    t_state             r_state;
    t_mode              r_mode;
    logic [15:0]        r_active_id;
    logic               r_id_valid;
    logic signed [15:0] r_prev_x, r_prev_y, r_origin_x, r_origin_y, r_wheel_x, r_wheel_y;
    logic               r_long_fired;
    logic [19:0]        r_since;
    logic [PW-1:0]      r_head;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_widx;
    logic [VM_W-1:0]    r_vel_mag;
    logic               r_vel_neg;
    logic               r_inertia_on;
    logic [7:0]         r_phase;

    // work registers
    tgm_pkg::t_in_word     r_in;
    logic signed [16:0]    r_dy;
    logic signed [SUM_W-1:0] r_sum;
    logic [NUM_W-1:0]      r_q;
    logic                  r_vneg;
    logic [PROD_W-1:0]     r_prod;
    tgm_pkg::t_out_word    r_res [2];
    logic [1:0]            r_nres;
    logic [1:0]            r_idx;
    logic                  r_ov;
    tgm_pkg::t_out_word    r_ow;

    // sample store
    logic [19:0]        mem_time [SAMPLE_DEPTH];
    logic signed [16:0] mem_dy   [SAMPLE_DEPTH];
    logic [19:0]        r_rd_time;
    logic signed [16:0] r_rd_dy;

    logic               w_we;
    logic [PW-1:0]      w_waddr;
    logic [PW-1:0]      w_raddr;
    logic               w_full;
    logic [PW-1:0]      w_head1;
    logic [CW-1:0]      w_count1;

    logic signed [16:0] w_dy;
    logic [16:0]        w_adx, w_ady;
    logic               w_mv_match, w_exceed, w_to_scroll, w_to_drag, w_big_dy;
    t_mode              w_mode_eff;
    logic               w_up_match;
    logic [19:0]        w_since_inc;
    logic [7:0]         w_phase_inc;
    logic               w_long;

    logic [MA_W-1:0]    w_mul_a;
    logic [15:0]        w_mul_b;
    logic [14:0]        w_wh_a;
    logic [MA_W-1:0]    w_sm;
    logic [VM_W-1:0]    w_sm_cap;
    logic [VM_W-1:0]    w_dm;
    logic [15:0]        w_hw;
    logic signed [SUM_W-1:0] w_sum_nx;

    logic               w_load;
    tgm_pkg::t_out_word w_send_word;

    logic               w_div_start;
    logic               w_div_done;
    logic [NUM_W-1:0]   w_div_quo;

    tgm_div #(
        .NUM_W (NUM_W),
        .DEN_W (20)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   ({abs_sum(r_sum), {FRAC_BITS{1'b0}}}),
        .i_den   (r_since),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    assign w_div_start = (r_state == S_DSTART);

    always_comb begin
        w_dy   = $signed({r_in.pos_y[15], r_in.pos_y}) - $signed({r_prev_y[15], r_prev_y});
        w_adx  = abs17($signed({r_in.pos_x[15], r_in.pos_x})
                       - $signed({r_origin_x[15], r_origin_x}));
        w_ady  = abs17($signed({r_in.pos_y[15], r_in.pos_y})
                       - $signed({r_origin_y[15], r_origin_y}));
        w_mv_match = r_in.is_touch && (r_mode != M_IDLE) && r_id_valid
                     && (r_in.pointer_id == r_active_id);
        w_exceed    = (w_adx > {9'd0, r_cfg_thr}) || (w_ady > {9'd0, r_cfg_thr});
        w_to_scroll = (r_mode == M_PEND) && w_exceed && (w_ady >= w_adx);
        w_to_drag   = (r_mode == M_PEND) && w_exceed && !(w_ady >= w_adx);
        w_mode_eff  = w_to_scroll ? M_SCROLL : (w_to_drag ? M_DRAG : r_mode);
        w_big_dy    = (w_dy > tgm_pkg::SMALL_DY) || (w_dy < -tgm_pkg::SMALL_DY);
        w_up_match  = r_in.is_touch && r_id_valid && (r_in.pointer_id == r_active_id);

        w_since_inc = (r_since == tgm_pkg::TIME_MAX) ? r_since : r_since + 20'd1;
        w_phase_inc = (r_phase == 8'hFF) ? r_phase : r_phase + 8'd1;
        w_long = (r_mode == M_PEND) && !r_long_fired && (w_since_inc >= {4'd0, r_cfg_long});

        w_full   = (r_count == CW'(SAMPLE_DEPTH));
        w_head1  = w_full ? wrap_add(r_head, CW'(1)) : r_head;
        w_count1 = w_full ? r_count - CW'(1) : r_count;
        w_we     = (r_state == S_REC);
        w_waddr  = wrap_add(w_head1, w_count1);
        w_raddr  = wrap_add(r_head, r_widx);

        case (r_state)
            S_WMUL: begin
                w_mul_a = MA_W'(abs17(r_dy));
                w_mul_b = 16'(r_cfg_gain);
            end
            S_SMUL: begin
                w_mul_a = (r_q >= NUM_W'(Q_CLAMP)) ? Q_CLAMP : MA_W'(r_q);
                w_mul_b = tgm_pkg::START_SCALE;
            end
            S_DMUL: begin
                w_mul_a = MA_W'(r_vel_mag);
                w_mul_b = r_cfg_decay;
            end
            S_HMUL: begin
                w_mul_a = MA_W'(r_vel_mag);
                w_mul_b = tgm_pkg::WHEEL_MULT;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase

        w_wh_a   = (r_prod > PROD_W'(r_cfg_limit)) ? r_cfg_limit : r_prod[14:0];
        w_sm     = r_prod[PROD_W-1:16];
        w_sm_cap = (w_sm > MA_W'(VEL_CAP)) ? VEL_CAP : VM_W'(w_sm);
        w_dm     = VM_W'(r_prod[PROD_W-1:16]);
        w_hw     = 16'(r_prod >> FRAC_BITS);
        w_sum_nx = r_sum + SUM_W'(r_rd_dy);

        // next output word and whether it is loaded this cycle
        w_load           = (r_state == S_SEND) && (!r_ov || !i_out_stall) && (r_idx < r_nres);
        w_send_word      = r_res[r_idx[0]];
        w_send_word.last = (2'(r_idx + 2'd1) == r_nres);
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_time[w_waddr] <= r_since;
            mem_dy[w_waddr]   <= r_dy;
        end
        r_rd_time <= mem_time[w_raddr];
        r_rd_dy   <= mem_dy[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_thr       <= tgm_pkg::RST_MOVE_THRESHOLD;
            r_cfg_long      <= tgm_pkg::RST_LONG_PRESS;
            r_cfg_gain      <= tgm_pkg::RST_WHEEL_GAIN;
            r_cfg_limit     <= tgm_pkg::RST_WHEEL_LIMIT;
            r_cfg_window    <= tgm_pkg::RST_WINDOW;
            r_cfg_period    <= tgm_pkg::RST_INERTIA_PERIOD;
            r_cfg_decay     <= tgm_pkg::RST_INERTIA_DECAY;
            r_cfg_start_min <= tgm_pkg::RST_INERTIA_START;
            r_state      <= S_IDLE;
            r_mode       <= M_IDLE;
            r_active_id  <= '0;
            r_id_valid   <= 1'b0;
            r_prev_x     <= '0;
            r_prev_y     <= '0;
            r_origin_x   <= '0;
            r_origin_y   <= '0;
            r_wheel_x    <= '0;
            r_wheel_y    <= '0;
            r_long_fired <= 1'b0;
            r_since      <= '0;
            r_head       <= '0;
            r_count      <= '0;
            r_widx       <= '0;
            r_vel_mag    <= '0;
            r_vel_neg    <= 1'b0;
            r_inertia_on <= 1'b0;
            r_phase      <= '0;
            r_nres       <= '0;
            r_idx        <= '0;
            r_ov         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tgm_pkg::CFG_MOVE_THRESHOLD: r_cfg_thr       <= i_cfg_data[7:0];
                    tgm_pkg::CFG_LONG_PRESS:     r_cfg_long      <= i_cfg_data[15:0];
                    tgm_pkg::CFG_WHEEL_GAIN:     r_cfg_gain      <= i_cfg_data[3:0];
                    tgm_pkg::CFG_WHEEL_LIMIT:    r_cfg_limit     <= i_cfg_data[14:0];
                    tgm_pkg::CFG_WINDOW:         r_cfg_window    <= i_cfg_data[9:0];
                    tgm_pkg::CFG_INERTIA_PERIOD: r_cfg_period    <= i_cfg_data[7:0];
                    tgm_pkg::CFG_INERTIA_DECAY:  r_cfg_decay     <= i_cfg_data[15:0];
                    tgm_pkg::CFG_INERTIA_START:  r_cfg_start_min <= i_cfg_data;
                    default: ;
                endcase
            end

            r_prod <= PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

            // drop the output word once taken, unless the next one replaces it
            if (w_load) r_ov <= 1'b1;
            else if (r_ov && !i_out_stall) r_ov <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in    <= i_in_word;
                        r_nres  <= '0;
                        r_idx   <= '0;
                        r_state <= S_EXEC;
                    end
                end

                S_EXEC: begin
                    r_state <= S_SEND;
                    unique case (r_in.req_type)
                        tgm_pkg::REQ_DOWN: begin
                            if (r_in.is_touch && r_in.target_active && r_mode == M_IDLE) begin
                                r_mode       <= M_PEND;
                                r_active_id  <= r_in.pointer_id;
                                r_id_valid   <= 1'b1;
                                r_prev_x     <= r_in.pos_x;
                                r_prev_y     <= r_in.pos_y;
                                r_origin_x   <= r_in.pos_x;
                                r_origin_y   <= r_in.pos_y;
                                r_long_fired <= 1'b0;
                                r_since      <= '0;
                                r_count      <= '0;
                            end
                        end
                        tgm_pkg::REQ_MOVE: begin
                            if (w_mv_match) begin
                                r_mode   <= w_mode_eff;
                                r_prev_x <= r_in.pos_x;
                                r_prev_y <= r_in.pos_y;
                                r_dy     <= w_dy;
                                if (w_to_scroll) begin
                                    r_wheel_x <= r_origin_x;
                                    r_wheel_y <= r_origin_y;
                                end
                                if (w_to_drag) begin
                                    r_res[0] <= '{tgm_pkg::ACT_LPRESS, r_in.pos_x,
                                                  r_in.pos_y, 16'sd0, 1'b0};
                                    r_res[1] <= '{tgm_pkg::ACT_MOVE, r_in.pos_x,
                                                  r_in.pos_y, 16'sd0, 1'b0};
                                    r_nres   <= 2'd2;
                                end else if (w_mode_eff == M_DRAG) begin
                                    r_res[0] <= '{tgm_pkg::ACT_MOVE, r_in.pos_x,
                                                  r_in.pos_y, 16'sd0, 1'b0};
                                    r_nres   <= 2'd1;
                                end else if (w_mode_eff == M_SCROLL && w_big_dy) begin
                                    r_state <= S_WMUL;
                                end
                            end
                        end
                        tgm_pkg::REQ_UP: begin
                            r_mode     <= M_IDLE;
                            r_id_valid <= 1'b0;
                            if (w_up_match) begin
                                r_long_fired <= 1'b0;
                                if (r_mode == M_SCROLL) begin
                                    if (r_count < CW'(2) || r_since == '0) begin
                                        r_q     <= '0;
                                        r_vneg  <= 1'b0;
                                        r_state <= S_SMUL;
                                    end else begin
                                        r_sum   <= '0;
                                        r_widx  <= '0;
                                        r_state <= S_VRD;
                                    end
                                end else if (r_mode == M_DRAG) begin
                                    r_res[0] <= '{tgm_pkg::ACT_LRELEASE, r_prev_x, r_prev_y,
                                                  16'sd0, 1'b0};
                                    r_nres   <= 2'd1;
                                end else if (r_mode == M_PEND && !r_long_fired) begin
                                    r_res[0] <= '{tgm_pkg::ACT_LCLICK, r_origin_x, r_origin_y,
                                                  16'sd0, 1'b0};
                                    r_nres   <= 2'd1;
                                end
                            end
                        end
                        tgm_pkg::REQ_TICK: begin
                            r_since <= w_since_inc;
                            if (w_long) begin
                                r_long_fired <= 1'b1;
                                r_res[0] <= '{tgm_pkg::ACT_RCLICK, r_origin_x, r_origin_y,
                                              16'sd0, 1'b0};
                                r_nres   <= 2'd1;
                            end
                            if (r_inertia_on) begin
                                if (w_phase_inc >= r_cfg_period) begin
                                    r_phase <= '0;
                                    r_state <= S_DMUL;
                                end else begin
                                    r_phase <= w_phase_inc;
                                end
                            end
                        end
                        default: ;
                    endcase
                end

                S_WMUL: r_state <= S_WEMIT;

                S_WEMIT: begin
                    r_res[0] <= '{tgm_pkg::ACT_WHEEL, r_wheel_x, r_wheel_y,
                                  r_dy[16] ? -$signed({1'b0, w_wh_a}) : $signed({1'b0, w_wh_a}),
                                  1'b0};
                    r_nres   <= 2'd1;
                    r_state  <= S_REC;
                end

                S_REC: begin
                    // drop the oldest entry when full, then append
                    r_head  <= w_head1;
                    r_count <= w_count1 + CW'(1);
                    r_widx  <= '0;
                    r_state <= S_WRD;
                end

                S_WRD: r_state <= S_WCHK;

                S_WCHK: begin
                    if (r_count != '0 && (r_since - r_rd_time) > {10'd0, r_cfg_window}) begin
                        r_head  <= wrap_add(r_head, CW'(1));
                        r_count <= r_count - CW'(1);
                        r_state <= S_WRD;
                    end else begin
                        r_state <= S_SEND;
                    end
                end

                S_VRD: r_state <= S_VACC;

                S_VACC: begin
                    // take a sample only if it grows the magnitude
                    if (abs_sum(w_sum_nx) > abs_sum(r_sum)) r_sum <= w_sum_nx;
                    r_widx <= r_widx + CW'(1);
                    if (r_widx + CW'(1) == r_count) r_state <= S_DSTART;
                    else r_state <= S_VRD;
                end

                S_DSTART: begin
                    r_vneg  <= r_sum[SUM_W-1];
                    r_state <= S_DWAIT;
                end

                S_DWAIT: begin
                    if (w_div_done) begin
                        r_q     <= w_div_quo;
                        r_state <= S_SMUL;
                    end
                end

                S_SMUL: r_state <= S_SSET;

                S_SSET: begin
                    r_vel_mag <= w_sm_cap;
                    r_vel_neg <= r_vneg && (w_sm_cap != '0);
                    if (r_q >= NUM_W'(r_cfg_start_min)) begin
                        r_inertia_on <= 1'b1;
                        r_phase      <= '0;
                    end
                    r_count  <= '0;
                    r_res[0] <= '{tgm_pkg::ACT_PARK, 16'sd0, 16'sd0, 16'sd0, 1'b0};
                    r_nres   <= 2'd1;
                    r_state  <= S_SEND;
                end

                S_DMUL: r_state <= S_DSET;

                S_DSET: begin
                    r_vel_mag <= w_dm;
                    r_vel_neg <= r_vel_neg && (w_dm != '0);
                    if (w_dm < STOP_MIN) begin
                        r_inertia_on      <= 1'b0;
                        r_res[r_nres[0]]  <= '{tgm_pkg::ACT_PARK, 16'sd0, 16'sd0,
                                               16'sd0, 1'b0};
                        r_nres            <= r_nres + 2'd1;
                        r_state           <= S_SEND;
                    end else begin
                        r_state <= S_HMUL;
                    end
                end

                S_HMUL: r_state <= S_HEMIT;

                S_HEMIT: begin
                    r_res[r_nres[0]] <= '{tgm_pkg::ACT_WHEEL, r_wheel_x, r_wheel_y,
                                          r_vel_neg ? -$signed(w_hw) : $signed(w_hw), 1'b0};
                    r_nres  <= r_nres + 2'd1;
                    r_state <= S_SEND;
                end

                S_SEND: begin
                    if (!r_ov || !i_out_stall) begin
                        if (r_idx < r_nres) begin
                            r_ow  <= w_send_word;
                            r_idx <= r_idx + 2'd1;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_word  = r_ow;

    `TGM_ASSERT_NOW(a_vel_cap, 1'b1, r_vel_mag <= VEL_CAP, "inertia speed above cap")
    `TGM_ASSERT_NOW(a_count_max, 1'b1, r_count <= CW'(SAMPLE_DEPTH), "sample count overflow")
    `TGM_ASSERT_NOW(a_id_mode, 1'b1, r_id_valid == (r_mode != M_IDLE), "id and mode disagree")
    `TGM_ASSERT_NEXT(a_busy, i_in_valid && !o_in_stall, o_in_stall, "not busy after accept")

endmodule
